// ----- src/single_half_float_converter_top_defines.svh -----
// Assertion macros used by the converter's checker file.
`ifndef SINGLE_HALF_FLOAT_CONVERTER_TOP_DEFINES_SVH
`define SINGLE_HALF_FLOAT_CONVERTER_TOP_DEFINES_SVH

// Property checked on every rising edge, ignored while reset is high.
`define SHFC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Property checked on every rising edge, reset included.
`define SHFC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- src/shfc_pkg.sv -----
// Types and constants of the single/half float converter.
`default_nettype none

package shfc_pkg;

  // Result class decided in the first stage; it selects the final assembly.
  typedef enum logic [3:0] {
    KIND_H_NAN  = 4'd0,
    KIND_H_ZERO = 4'd1,
    KIND_H_SUB  = 4'd2,
    KIND_H_NORM = 4'd3,
    KIND_H_INF  = 4'd4,
    KIND_S_INF  = 4'd5,
    KIND_S_QNAN = 4'd6,
    KIND_S_ZERO = 4'd7,
    KIND_S_SUB  = 4'd8,
    KIND_S_NORM = 4'd9
  } kind_t;

  localparam logic [7:0]  SINGLE_EXP_MAX  = 8'hFF;
  localparam logic [7:0]  EXP_REBIAS      = 8'd112;
  localparam logic [7:0]  HALF_SUB_LOW    = 8'd103;
  localparam logic [7:0]  HALF_NORM_HIGH  = 8'd142;
  localparam logic [23:0] ROUND_INC       = 24'h001000;
  localparam logic [4:0]  HALF_EXP_MAX    = 5'h1F;
  localparam logic [15:0] HALF_POS_INF    = 16'h7C00;
  localparam logic [15:0] HALF_NEG_INF    = 16'hFC00;
  localparam logic [14:0] HALF_INF_BODY   = 15'h7C00;
  localparam logic [31:0] HALF_NAN_WORD   = 32'h00007C01;
  localparam logic [31:0] SINGLE_QNAN     = 32'h7FC00000;
  localparam logic [3:0]  HALF_FRAC_BITS  = 4'd10;

endpackage

`default_nettype wire

// ----- src/single_half_float_converter_top.sv -----
// Three-stage pipelined converter between binary32 and binary16 patterns.
//
// Input channel: in_valid, in_stall, op, value_in. A word is taken at a
// rising edge with in_valid high and in_stall low. op = 0 converts the
// binary32 pattern in value_in to binary16; op = 1 widens the binary16
// pattern in value_in[15:0] to binary32.
// Output channel: out_valid, out_stall, value_out. A half result sits in
// value_out[15:0] with the upper bits zero.
// Every word gives exactly one result, in order. With no stall a taken word
// moves through the stage 1, stage 2 and output registers in turn, and
// one word per cycle is sustained. The three register stages are classify
// and round, shift, and assemble into the output register.
// When the receiver stalls, the output holds and stages behind it keep
// filling; in_stall rises only when all three stages hold a word.
// A synchronous reset empties the pipeline; nothing else needs clearing.
`default_nettype none

module single_half_float_converter_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [31:0] value_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      value_out
);

  // Stage registers.
  logic                s1_valid;
  shfc_pkg::kind_t     s1_kind;
  logic                s1_sign;
  logic [7:0]          s1_exp;
  logic [10:0]         s1_mant;
  logic [3:0]          s1_shift;

  logic                s2_valid;
  shfc_pkg::kind_t     s2_kind;
  logic                s2_sign;
  logic [14:0]         s2_hbody;
  logic [7:0]          s2_sexp;
  logic [9:0]          s2_sfrac;

  // Next values.
  shfc_pkg::kind_t     s1_kind_next;
  logic                s1_sign_next;
  logic [7:0]          s1_exp_next;
  logic [10:0]         s1_mant_next;
  logic [3:0]          s1_shift_next;
  logic [14:0]         s2_hbody_next;
  logic [9:0]          s2_sfrac_next;
  logic [31:0]         value_out_next;

  // Advance enables: a stage loads when it is empty or its word moves on.
  logic adv3;
  logic adv2;
  logic adv1;

  assign adv3     = !out_valid || !out_stall;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;

  // Stage 1 decode fields.
  logic [7:0]  bexp;
  logic [22:0] smant;
  logic [23:0] round_sum;
  logic [15:0] hword;
  logic [4:0]  hexp;
  logic [9:0]  hfrac;
  logic [3:0]  lead_pos;

  assign bexp      = value_in[30:23];
  assign smant     = value_in[22:0];
  assign round_sum = {1'b0, smant} + shfc_pkg::ROUND_INC;
  assign hword     = value_in[15:0];
  assign hexp      = hword[14:10];
  assign hfrac     = hword[9:0];

  // Position of the leading one of a half subnormal fraction.
  always_comb begin
    lead_pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hfrac[i]) begin
        lead_pos = 4'(i);
      end
    end
  end

  always_comb begin
    s1_kind_next  = shfc_pkg::KIND_H_ZERO;
    s1_sign_next  = 1'b0;
    s1_exp_next   = 8'd0;
    s1_mant_next  = 11'd0;
    s1_shift_next = 4'd0;
    if (!op) begin
      s1_sign_next = value_in[31];
      s1_mant_next = round_sum[23:13];
      if (bexp == shfc_pkg::SINGLE_EXP_MAX && smant != 23'd0) begin
        s1_kind_next = shfc_pkg::KIND_H_NAN;
      end else if (bexp < shfc_pkg::HALF_SUB_LOW) begin
        s1_kind_next = shfc_pkg::KIND_H_ZERO;
      end else if (bexp <= shfc_pkg::EXP_REBIAS) begin
        s1_kind_next  = shfc_pkg::KIND_H_SUB;
        s1_shift_next = 4'(shfc_pkg::EXP_REBIAS - bexp);
      end else if (bexp > shfc_pkg::HALF_NORM_HIGH) begin
        s1_kind_next = shfc_pkg::KIND_H_INF;
      end else begin
        s1_kind_next = shfc_pkg::KIND_H_NORM;
        s1_exp_next  = bexp - shfc_pkg::EXP_REBIAS;
      end
    end else begin
      s1_sign_next = hword[15];
      s1_mant_next = {1'b0, hfrac};
      if (hword == shfc_pkg::HALF_POS_INF || hword == shfc_pkg::HALF_NEG_INF) begin
        s1_kind_next = shfc_pkg::KIND_S_INF;
      end else if (hexp == shfc_pkg::HALF_EXP_MAX) begin
        s1_kind_next = shfc_pkg::KIND_S_QNAN;
      end else if (hexp == 5'd0) begin
        if (hfrac == 10'd0) begin
          s1_kind_next = shfc_pkg::KIND_S_ZERO;
        end else begin
          s1_kind_next  = shfc_pkg::KIND_S_SUB;
          s1_exp_next   = {4'd0, lead_pos} + shfc_pkg::HALF_SUB_LOW;
          s1_shift_next = shfc_pkg::HALF_FRAC_BITS - lead_pos;
        end
      end else begin
        s1_kind_next = shfc_pkg::KIND_S_NORM;
        s1_exp_next  = {3'd0, hexp} + shfc_pkg::EXP_REBIAS;
      end
    end
  end

  // Stage 2: subnormal rounding shift, normal exponent add, renormalize.
  logic [11:0] sub_sum;
  logic [11:0] sub_shifted;
  logic [11:0] sub_round;
  logic [9:0]  norm_frac;

  assign sub_sum     = 12'h400 + {1'b0, s1_mant};
  assign sub_shifted = sub_sum >> s1_shift;
  assign sub_round   = sub_shifted + 12'd1;
  assign norm_frac   = s1_mant[9:0] << s1_shift;

  always_comb begin
    s2_hbody_next = 15'd0;
    s2_sfrac_next = s1_mant[9:0];
    case (s1_kind)
      shfc_pkg::KIND_H_SUB: begin
        // A carry out of the second round step lands on the lowest exponent.
        s2_hbody_next = {4'd0, sub_round[11:1]};
      end
      shfc_pkg::KIND_H_NORM: begin
        // The rounding carry adds into the exponent and may reach infinity.
        s2_hbody_next = {s1_exp[4:0], 10'd0} + {4'd0, s1_mant};
      end
      shfc_pkg::KIND_S_SUB: begin
        s2_sfrac_next = norm_frac;
      end
      default: begin
        s2_hbody_next = 15'd0;
      end
    endcase
  end

  // Stage 3: assemble the output word.
  always_comb begin
    case (s2_kind)
      shfc_pkg::KIND_H_NAN:  value_out_next = shfc_pkg::HALF_NAN_WORD;
      shfc_pkg::KIND_H_ZERO: value_out_next = {16'd0, s2_sign, 15'd0};
      shfc_pkg::KIND_H_SUB:  value_out_next = {16'd0, s2_sign, s2_hbody};
      shfc_pkg::KIND_H_NORM: value_out_next = {16'd0, s2_sign, s2_hbody};
      shfc_pkg::KIND_H_INF:  value_out_next = {16'd0, s2_sign, shfc_pkg::HALF_INF_BODY};
      shfc_pkg::KIND_S_INF:  value_out_next = {s2_sign, shfc_pkg::SINGLE_EXP_MAX, 23'd0};
      shfc_pkg::KIND_S_QNAN: value_out_next = shfc_pkg::SINGLE_QNAN;
      shfc_pkg::KIND_S_ZERO: value_out_next = {s2_sign, 31'd0};
      shfc_pkg::KIND_S_SUB:  value_out_next = {s2_sign, s2_sexp, s2_sfrac, 13'd0};
      shfc_pkg::KIND_S_NORM: value_out_next = {s2_sign, s2_sexp, s2_sfrac, 13'd0};
      default:               value_out_next = 32'd0;
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_kind  <= s1_kind_next;
      s1_sign  <= s1_sign_next;
      s1_exp   <= s1_exp_next;
      s1_mant  <= s1_mant_next;
      s1_shift <= s1_shift_next;
    end
    if (adv2) begin
      s2_kind  <= s1_kind;
      s2_sign  <= s1_sign;
      s2_hbody <= s2_hbody_next;
      s2_sexp  <= s1_exp;
      s2_sfrac <= s2_sfrac_next;
    end
    if (adv3) begin
      value_out <= value_out_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/shfc_checker.sv -----
// Port-level assertions for the converter, bound to its top level.
`default_nettype none
`include "single_half_float_converter_top_defines.svh"

module shfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] value_out
);

  // A held result stays offered.
  `SHFC_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)

  // A held result does not change.
  `SHFC_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(value_out))

  // An accepted word reaches the output when out_stall stays low on its way.
  `SHFC_ASSERT(a_latency, clk, rst, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)

  // Reset empties the pipeline and opens the input.
  `SHFC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !in_stall)

endmodule

bind single_half_float_converter_top shfc_checker u_shfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value_out (value_out)
);

`default_nettype wire
